@@ rtl/core/tun_pkg.sv @@
// Shared widths, payload types and flag bundle for the triangle unit normal pipeline.
// Depends on nothing; every module of the block but tun_sqrt imports it.
package tun_pkg;

	localparam int COORD_WIDTH  = 24;
	localparam int NORMAL_WIDTH = 16;

	// Bit length that the largest cross component is brought to before the length.
	localparam int NORM_BITS = 31;

	localparam int EDGE_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = CROSS_W - 1;
	localparam int NLEN_W  = $clog2(MAG_W + 1);
	localparam int SQ_W    = 2 * NORM_BITS;
	localparam int SUM_W   = SQ_W + 2;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int QUOT_W  = NORMAL_WIDTH + 1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] v0_x;
		logic signed [COORD_WIDTH-1:0] v0_y;
		logic signed [COORD_WIDTH-1:0] v0_z;
		logic signed [COORD_WIDTH-1:0] v1_x;
		logic signed [COORD_WIDTH-1:0] v1_y;
		logic signed [COORD_WIDTH-1:0] v1_z;
		logic signed [COORD_WIDTH-1:0] v2_x;
		logic signed [COORD_WIDTH-1:0] v2_y;
		logic signed [COORD_WIDTH-1:0] v2_z;
	} triangle_t;

	typedef struct packed {
		logic signed [NORMAL_WIDTH-1:0] normal_x;
		logic signed [NORMAL_WIDTH-1:0] normal_y;
		logic signed [NORMAL_WIDTH-1:0] normal_z;
		logic                           degenerate;
	} normal_t;

	// Per-item flags that ride along with the data through the back half.
	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} flags_t;

endpackage

@@ rtl/core/tun_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels in step with each radicand. Depends on no package.
module tun_sqrt #(
	parameter int SUM_W  = 64,
	parameter int SIDE_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [SUM_W-1:0]     radicand,
	input  logic [SIDE_W-1:0]    side_in,
	output logic                 out_valid,
	output logic [SUM_W/2-1:0]   root,
	output logic [SIDE_W-1:0]    side_out
);
	localparam int RW = SUM_W / 2;

	logic              vld_s  [RW+1];
	logic [SUM_W-1:0]  rad_s  [RW+1];
	logic [RW:0]       rem_s  [RW+1];
	logic [RW-1:0]     root_s [RW+1];
	logic [SIDE_W-1:0] side_s [RW+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+2:0] cur;
		logic [RW+2:0] trial;
		logic          ge;

		always_comb begin
			cur   = {rem_s[k], rad_s[k][SUM_W-1 -: 2]};
			trial = {1'b0, root_s[k], 2'b01};
			ge    = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][SUM_W-3:0], 2'b00};
				// The remainder never exceeds twice the partial root.
				rem_s[k+1]  <= ge ? (RW+1)'(cur - trial) : (RW+1)'(cur);
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign root      = root_s[RW];
	assign side_out  = side_s[RW];

endmodule

@@ rtl/core/tun_div.sv @@
// Three-lane pipelined restoring divider: rounded m * 2^(NORMAL_WIDTH-1) / len.
// Depends on tun_pkg for the flag bundle.
module tun_div #(
	parameter int NORMAL_WIDTH = 16,
	parameter int NORM_BITS    = 31,
	parameter int ROOT_W       = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [2:0][NORM_BITS-1:0]           mag,
	input  logic [ROOT_W-1:0]                   len,
	input  tun_pkg::flags_t                     flags_in,
	output logic                                out_valid,
	output logic [2:0][NORMAL_WIDTH:0]          quot,
	output tun_pkg::flags_t                     flags_out
);
	import tun_pkg::*;

	localparam int QW    = NORMAL_WIDTH + 1;
	localparam int NUM_W = NORM_BITS + NORMAL_WIDTH;

	logic                     vld_s  [QW+1];
	logic [2:0][QW-1:0]       low_s  [QW+1];
	logic [2:0][ROOT_W-1:0]   rem_s  [QW+1];
	logic [2:0][QW-1:0]       quo_s  [QW+1];
	logic [ROOT_W-1:0]        len_s  [QW+1];
	flags_t                   flg_s  [QW+1];

	logic [2:0][NUM_W-1:0] num;

	// Numerator with half the divisor added, so the quotient rounds to nearest.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = NUM_W'({mag[i], {(NORMAL_WIDTH-1){1'b0}}}) + NUM_W'(len >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= ROOT_W'(num[i][NUM_W-1:QW]);
				low_s[0][i] <= num[i][QW-1:0];
				quo_s[0][i] <= '0;
			end
			len_s[0] <= len;
			flg_s[0] <= flags_in;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [2:0][ROOT_W:0] cur;
		logic [2:0]           ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				cur[i] = {rem_s[k][i], low_s[k][i][QW-1]};
				ge[i]  = cur[i] >= {1'b0, len_s[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[k+1][i] <= ge[i] ? ROOT_W'(cur[i] - {1'b0, len_s[k]})
					                       : ROOT_W'(cur[i]);
					low_s[k+1][i] <= {low_s[k][i][QW-2:0], 1'b0};
					quo_s[k+1][i] <= {quo_s[k][i][QW-2:0], ge[i]};
				end
				len_s[k+1] <= len_s[k];
				flg_s[k+1] <= flg_s[k];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quot      = quo_s[QW];
	assign flags_out = flg_s[QW];

endmodule

@@ rtl/core/triangle_unit_normal.sv @@
// Stages: 7 front stages, 32 root stages, 18 divider stages and the output
// register lie between transfer in and result valid.
// Throughput: one triangle per cycle; the whole pipeline advances together and
// holds while a waiting result is stalled. Stage count is set by the bit-serial
// square root and divider. Reset clears all valid bits; data is not reset.
module triangle_unit_normal (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                triangle_valid,
	output logic                triangle_stall,
	input  tun_pkg::triangle_t  triangle,
	output logic                result_valid,
	input  logic                result_stall,
	output tun_pkg::normal_t    result
);
	import tun_pkg::*;

	localparam logic [NLEN_W-1:0] NB = NLEN_W'(NORM_BITS);
	localparam logic [QUOT_W-1:0] MAXV = QUOT_W'((1 << (NORMAL_WIDTH - 1)) - 1);
	localparam int SIDE_W = 3 * NORM_BITS + $bits(flags_t);

	logic en;
	logic result_valid_q;
	normal_t result_q;

	assign en = !(result_valid_q && result_stall);
	assign triangle_stall = !en;

	// Stage 1: edge vectors.
	logic signed [COORD_WIDTH-1:0] v0 [3], v1 [3], v2 [3];
	logic signed [EDGE_W-1:0] e1_s1 [3], e2_s1 [3];
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	assign v0 = '{triangle.v0_x, triangle.v0_y, triangle.v0_z};
	assign v1 = '{triangle.v1_x, triangle.v1_y, triangle.v1_z};
	assign v2 = '{triangle.v2_x, triangle.v2_y, triangle.v2_z};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= {v1[i][COORD_WIDTH-1], v1[i]} - {v0[i][COORD_WIDTH-1], v0[i]};
				e2_s1[i] <= {v2[i][COORD_WIDTH-1], v2[i]} - {v0[i][COORD_WIDTH-1], v0[i]};
			end
		end
	end

	// Stage 2: the six partial products of the cross product.
	logic signed [PROD_W-1:0] p_s2 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
		end
	end

	// Stage 3: cross components as sign and magnitude.
	logic signed [CROSS_W-1:0] c [3];
	logic [MAG_W-1:0] mag_s3 [3];
	logic [2:0] neg_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c[i] = {p_s2[2*i][PROD_W-1], p_s2[2*i]} - {p_s2[2*i+1][PROD_W-1], p_s2[2*i+1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= c[i][CROSS_W-1];
				mag_s3[i] <= c[i][CROSS_W-1] ? MAG_W'(-c[i]) : MAG_W'(c[i]);
			end
		end
	end

	// Stage 4: bit length of the largest magnitude.
	logic [MAG_W-1:0] any;
	logic [NLEN_W-1:0] nlen;
	logic [NLEN_W-1:0] nlen_s4;
	logic [MAG_W-1:0] mag_s4 [3];
	logic [2:0] neg_s4;

	always_comb begin
		any  = mag_s3[0] | mag_s3[1] | mag_s3[2];
		nlen = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (any[i]) nlen = NLEN_W'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nlen_s4 <= nlen;
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
		end
	end

	// Stage 5: common shift to a fixed bit length.
	logic [MAG_W-1:0] shifted [3];
	logic [NORM_BITS-1:0] m_s5 [3];
	flags_t flg_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (nlen_s4 > NB) shifted[i] = mag_s4[i] >> (nlen_s4 - NB);
			else              shifted[i] = mag_s4[i] << (NB - nlen_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) m_s5[i] <= shifted[i][NORM_BITS-1:0];
			flg_s5.neg   <= neg_s4;
			flg_s5.degen <= nlen_s4 == '0;
		end
	end

	// Stage 6: squares. Stage 7: their sum.
	logic [SQ_W-1:0] sq_s6 [3];
	logic [NORM_BITS-1:0] m_s6 [3], m_s7 [3];
	flags_t flg_s6, flg_s7;
	logic [SUM_W-1:0] sum_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s6[i] <= m_s5[i] * m_s5[i];
			m_s6   <= m_s5;
			flg_s6 <= flg_s5;
			sum_s7 <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
			m_s7   <= m_s6;
			flg_s7 <= flg_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= triangle_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Length by square root, then the three divisions.
	logic sq_valid;
	logic [ROOT_W-1:0] len;
	logic [SIDE_W-1:0] side_out;
	logic [2:0][NORM_BITS-1:0] m_len;
	flags_t flg_len;

	tun_sqrt #(
		.SUM_W  (SUM_W),
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.radicand  (sum_s7),
		.side_in   ({m_s7[0], m_s7[1], m_s7[2], flg_s7}),
		.out_valid (sq_valid),
		.root      (len),
		.side_out  (side_out)
	);

	assign {m_len[0], m_len[1], m_len[2], flg_len} = side_out;

	logic div_valid;
	logic [2:0][QUOT_W-1:0] quot;
	flags_t flg_div;

	tun_div #(
		.NORMAL_WIDTH (NORMAL_WIDTH),
		.NORM_BITS    (NORM_BITS),
		.ROOT_W       (ROOT_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.mag       (m_len),
		.len       (len),
		.flags_in  (flg_len),
		.out_valid (div_valid),
		.quot      (quot),
		.flags_out (flg_div)
	);

	// Saturate, apply the sign, and force zero for a degenerate triangle.
	logic [2:0][NORMAL_WIDTH-1:0] comp;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [NORMAL_WIDTH-1:0] sat;
			sat = (quot[i] > MAXV) ? NORMAL_WIDTH'(MAXV) : NORMAL_WIDTH'(quot[i]);
			if (flg_div.degen)      comp[i] = '0;
			else if (flg_div.neg[i]) comp[i] = -sat;
			else                     comp[i] = sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q.normal_x   <= comp[0];
			result_q.normal_y   <= comp[1];
			result_q.normal_z   <= comp[2];
			result_q.degenerate <= flg_div.degen;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	localparam logic signed [NORMAL_WIDTH-1:0] MINV = {1'b1, {(NORMAL_WIDTH-1){1'b0}}};

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
			result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0)
		else $error("degenerate result carries a nonzero normal");

	a_live_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.degenerate |->
			result.normal_x != '0 || result.normal_y != '0 || result.normal_z != '0)
		else $error("non-degenerate result has a zero normal");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			result.normal_x != MINV && result.normal_y != MINV && result.normal_z != MINV)
		else $error("normal component escaped saturation");

	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(vld_s7) && $stable(sum_s7))
		else $error("pipeline moved while the output was stalled");
`endif

endmodule

@@ tb/normal_checker.sv @@
// Watches the triangle and result channels of triangle_unit_normal, computes the
// expected unit normal of every accepted triangle and compares it with each result.
// Depends on tun_pkg.
module normal_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               triangle_valid,
	input  logic               triangle_stall,
	input  tun_pkg::triangle_t triangle,
	input  logic               result_valid,
	input  logic               result_stall,
	input  tun_pkg::normal_t   result,
	output int                 errors,
	output int                 pending
);
	import tun_pkg::*;

	normal_t expected_normals[$];

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic normal_t unit_normal(input triangle_t t);
		logic signed [63:0] e1 [3];
		logic signed [63:0] e2 [3];
		logic signed [127:0] cr [3];
		logic [127:0] mg [3];
		logic [63:0] m [3];
		logic [63:0] s, len, q;
		logic [15:0] o [3];
		int n, b;
		normal_t r;
		e1[0] = 64'(t.v1_x) - 64'(t.v0_x);
		e1[1] = 64'(t.v1_y) - 64'(t.v0_y);
		e1[2] = 64'(t.v1_z) - 64'(t.v0_z);
		e2[0] = 64'(t.v2_x) - 64'(t.v0_x);
		e2[1] = 64'(t.v2_y) - 64'(t.v0_y);
		e2[2] = 64'(t.v2_z) - 64'(t.v0_z);
		cr[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
		cr[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
		cr[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
		n = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
			b = 0;
			for (int k = 0; k < 128; k++) if (mg[i][k]) b = k + 1;
			if (b > n) n = b;
		end
		r = '0;
		if (n == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			if (n > NORM_BITS) m[i] = 64'(mg[i] >> (n - NORM_BITS));
			else m[i] = 64'(mg[i] << (NORM_BITS - n));
		end
		s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = root_floor(s);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << (NORMAL_WIDTH - 1)) + (len >> 1)) / len;
			if (q > 64'd32767) q = 64'd32767;
			o[i] = cr[i] < 0 ? 16'(-q) : 16'(q);
		end
		r.normal_x = o[0];
		r.normal_y = o[1];
		r.normal_z = o[2];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		normal_t want;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			if (triangle_valid && !triangle_stall)
				expected_normals.push_back(unit_normal(triangle));
			if (result_valid && !result_stall) begin
				if (expected_normals.size() == 0) begin
					if (errors < 10) $display("unexpected result %h", result);
					errors <= errors + 1;
				end else begin
					want = expected_normals.pop_front();
					if (want !== result) begin
						if (errors < 10)
							$display("mismatch: expected x=%0d y=%0d z=%0d deg=%0b, got x=%0d y=%0d z=%0d deg=%0b",
								want.normal_x, want.normal_y, want.normal_z, want.degenerate,
								result.normal_x, result.normal_y, result.normal_z,
								result.degenerate);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_normals.size();
		end
	end
endmodule

@@ tb/testbench.sv @@
// Stimulus and verdict for triangle_unit_normal: directed then random triangles under several
// idling and stall phases. Depends on tun_pkg, normal_checker and triangle_unit_normal.
module testbench;
	import tun_pkg::*;

	localparam int LATENCY = 58;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic triangle_valid;
	logic triangle_stall;
	triangle_t triangle;
	logic result_valid;
	logic result_stall;
	normal_t result;
	int errors;
	int pending;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;
	bit timed_out;

	triangle_unit_normal dut (
		.clk(clk), .arst_n(arst_n),
		.triangle_valid(triangle_valid), .triangle_stall(triangle_stall),
		.triangle(triangle),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	normal_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.triangle_valid(triangle_valid), .triangle_stall(triangle_stall),
		.triangle(triangle),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) result_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((triangle_valid && !triangle_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (timed_out) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [23:0] rand_coord(input int mode);
		case (mode)
			0: return 24'($urandom());
			1: return 24'($urandom_range(0, 200)) - 24'd100;
			2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
			default: return 24'($signed(12'($urandom())));
		endcase
	endfunction

	task automatic send(input triangle_t t);
		while ($urandom_range(99) < idle_pct) begin
			triangle_valid <= 1'b0;
			@(posedge clk);
		end
		triangle_valid <= 1'b1;
		triangle <= t;
		@(posedge clk);
		while (triangle_stall) @(posedge clk);
	endtask

	// Sends back to back when idling is off: valid stays high between transfers.
	task automatic send_rand(input int count);
		triangle_t t;
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(3);
			t = {rand_coord(mode), rand_coord(mode), rand_coord(mode),
				rand_coord(mode), rand_coord(mode), rand_coord(mode),
				rand_coord(mode), rand_coord(mode), rand_coord(mode)};
			// Some collinear or coincident triangles for the degenerate path.
			if ($urandom_range(9) == 0) begin
				t.v1_x = t.v0_x; t.v1_y = t.v0_y; t.v1_z = t.v0_z;
			end else if ($urandom_range(9) == 0) begin
				t.v2_x = t.v1_x + (t.v1_x - t.v0_x);
				t.v2_y = t.v1_y + (t.v1_y - t.v0_y);
				t.v2_z = t.v1_z + (t.v1_z - t.v0_z);
			end
			send(t);
		end
	endtask

	task automatic drain();
		triangle_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		triangle_valid = 1'b0;
		triangle = '0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: degenerate, axis normals, extremes, tiny components.
		send('0);
		send('{0, 0, 0, 24'd256, 0, 0, 0, 24'd256, 0});
		send('{0, 0, 0, 0, 24'd256, 0, 0, 0, 24'd256});
		send('{0, 0, 0, 0, 0, 24'd256, 24'd256, 0, 0});
		send('{0, 0, 0, 0, 24'd256, 0, 24'd256, 0, 0});
		send('{24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000, 24'h800000,
			24'h800000, 24'h7fffff, 24'h800000});
		send('{24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h7fffff,
			24'h7fffff, 24'h800000, 24'h800000});
		send('{24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff,
			24'h800000, 24'h800000, 24'h7fffff});
		send('{0, 0, 0, 24'h7fffff, 0, 0, 24'h7fffff, 24'h000001, 0});
		send('{0, 0, 0, 24'h7fffff, 24'h000001, 24'h000001, 0, 24'h7fffff, 0});
		send('{0, 0, 0, 24'd1, 0, 0, 0, 24'd1, 0});
		send('{5, 5, 5, 24'd6, 24'd6, 24'd6, 24'd7, 24'd7, 24'd7});
		send('{0, 0, 0, 24'd256, 24'd256, 0, 0, 24'd256, 24'd256});
		send('{24'hffffff, 24'hffffff, 24'hffffff, 24'hfffffe, 24'hffffff, 24'hffffff,
			24'hffffff, 24'hfffffe, 24'hfffffd});
		send('{24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa,
			24'h123456, 24'h654321, 24'hedcba9});

		// The sender holds off until every expected result is back.
		drain();
		send_rand(160);
		idle_pct = 66;
		send_rand(160);
		idle_pct = 0;
		stall_pct = 66;
		send_rand(160);
		idle_pct = 6;
		stall_pct = 6;
		send_rand(160);
		idle_pct = 0;
		stall_pct = 0;

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
